// ----- rtl/bihc_pkg.sv -----
// ----------------------------------------------------------------------------
// bihc_pkg: shared definitions for the boot image header checksum block
// Variant codes, command codes, seeds and the types passed between modules.
// ----------------------------------------------------------------------------
package bihc_pkg;

  localparam int TABLE_WORDS_DEF = 64;
  localparam int OUT_FIFO_DEPTH  = 8;
  localparam int WORD_W          = 32;
  localparam int VARIANT_W       = 3;

  localparam logic [VARIANT_W-1:0] VAR_6102 = 3'd0;
  localparam logic [VARIANT_W-1:0] VAR_6103 = 3'd1;
  localparam logic [VARIANT_W-1:0] VAR_6105 = 3'd2;
  localparam logic [VARIANT_W-1:0] VAR_6106 = 3'd3;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_WORD = 1'b1;

  localparam logic [WORD_W-1:0] SEED_6102 = 32'hF8CA4DDC;
  localparam logic [WORD_W-1:0] SEED_6103 = 32'hA3886759;
  localparam logic [WORD_W-1:0] SEED_6105 = 32'hDF26F436;
  localparam logic [WORD_W-1:0] SEED_6106 = 32'h1FEA617A;

  // Control beat into the accumulator update stage
  typedef struct packed {
    logic valid;
    logic start;
    logic use_table;
  } acc_ctrl_t;

  // The six running accumulators
  typedef struct packed {
    logic [WORD_W-1:0] running_sum;
    logic [WORD_W-1:0] carry_count;
    logic [WORD_W-1:0] xor_acc;
    logic [WORD_W-1:0] rotate_sum;
    logic [WORD_W-1:0] mix_value;
    logic [WORD_W-1:0] table_mix_sum;
  } acc_state_t;

  // One result beat
  typedef struct packed {
    logic [WORD_W-1:0] first;
    logic [WORD_W-1:0] second;
  } result_t;

  function automatic logic known_variant(input logic [VARIANT_W-1:0] v);
    return (v == VAR_6102) || (v == VAR_6103) || (v == VAR_6105) || (v == VAR_6106);
  endfunction

  function automatic logic [WORD_W-1:0] seed_of(input logic [VARIANT_W-1:0] v);
    logic [WORD_W-1:0] s;
    case (v)
      VAR_6102: s = SEED_6102;
      VAR_6103: s = SEED_6103;
      VAR_6105: s = SEED_6105;
      VAR_6106: s = SEED_6106;
      default:  s = '0;
    endcase
    return s;
  endfunction

  // Rotate left by the low five bits of the word itself; zero is identity
  function automatic logic [WORD_W-1:0] self_rotate(input logic [WORD_W-1:0] w);
    logic [2*WORD_W-1:0] dbl;
    dbl = {w, w} << w[4:0];
    return dbl[2*WORD_W-1:WORD_W];
  endfunction

endpackage

// ----- rtl/boot_image_header_checksum_top.sv -----
// ----------------------------------------------------------------------------
// boot_image_header_checksum_top: two-word boot image header checksum
// Streams image words through six accumulators and emits both header words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one beat per table load
//   (command 0, writes table slot table_index_i) or per image word
//   (command 1). The image word marked last_i closes the run and yields one
//   result beat on the output channel (out_valid_o / out_ready_i).
//   cfg_we_i writes the chip variant; write it only while the block is idle.
//   An unknown variant drops image words and emits nothing.
// Throughput: one beat per cycle while in_ready_o is high. Each word's fold
//   is one add-xor-rotate pass through the accumulator stage; the table
//   memory is read in the accept cycle so its registered data meets the word
//   in the cycle after. A last beat's result then passes, in order, the table
//   read, accumulator update, finalization register and result queue.
// Stall: results wait in an eight-beat queue. in_ready_o drops only while
//   eight results are pending (queued or in flight), so a stalled receiver
//   never loses a beat; non-producing beats may then also wait.
// Reset: variant 6102, no run open, queue empty. Table contents stay
//   undefined until loaded.
// ----------------------------------------------------------------------------
module boot_image_header_checksum_top
  import bihc_pkg::*;
#(
  parameter int TABLE_WORDS = TABLE_WORDS_DEF,
  parameter int AW          = $clog2(TABLE_WORDS)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [VARIANT_W-1:0] cfg_wdata_i,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 command_i,
  input  logic [AW-1:0]        table_index_i,
  input  logic [WORD_W-1:0]    data_word_i,
  input  logic                 last_i,
  // output channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [WORD_W-1:0]    checksum_first_o,
  output logic [WORD_W-1:0]    checksum_second_o
);

  localparam int RW = $clog2(OUT_FIFO_DEPTH + 1);

  // configuration register
  logic [VARIANT_W-1:0] variant_q;

  // accept-side run tracking
  logic          run_active_q, run_active_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [AW-1:0] rd_addr;
  logic          in_beat, word_beat, load_beat;

  // accumulator stage inputs
  logic              s1_valid_q, s1_start_q, s1_last_q;
  logic [WORD_W-1:0] s1_word_q, s1_rot_q;
  logic [WORD_W-1:0] table_word;
  acc_ctrl_t         acc_ctrl;
  acc_state_t        acc_state;

  // finalization and output
  logic          fin_valid_q;
  logic          res_valid;
  result_t       res_data;
  result_t       out_data;
  logic          out_beat;
  logic [RW-1:0] reserved_q;
  logic          reserve;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_q <= VAR_6102;
    end else if (cfg_we_i) begin
      variant_q <= cfg_wdata_i;
    end
  end

  // --------------------------------------------------------------------------
  // Accept and run bookkeeping
  // --------------------------------------------------------------------------
  assign in_ready_o = (reserved_q < RW'(OUT_FIFO_DEPTH));
  assign in_beat    = in_valid_i && in_ready_o;
  assign load_beat  = in_beat && (command_i == CMD_LOAD);
  assign word_beat  = in_beat && (command_i == CMD_WORD) && known_variant(variant_q);
  assign reserve    = word_beat && last_i;
  assign out_beat   = out_valid_o && out_ready_i;

  // A fresh run starts at slot zero
  assign rd_addr = run_active_q ? pos_q : '0;

  always_comb begin
    run_active_d = run_active_q;
    pos_d        = pos_q;
    if (word_beat) begin
      if (last_i) begin
        run_active_d = 1'b0;
        pos_d        = '0;
      end else begin
        run_active_d = 1'b1;
        pos_d        = rd_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_active_q <= 1'b0;
      pos_q        <= '0;
      reserved_q   <= '0;
    end else begin
      run_active_q <= run_active_d;
      pos_q        <= pos_d;
      reserved_q   <= reserved_q + RW'(reserve) - RW'(out_beat);
    end
  end

  // --------------------------------------------------------------------------
  // Boot-code table: load beats write, image beats read the run's slot
  // --------------------------------------------------------------------------
  bihc_table_mem #(
    .WORDS (TABLE_WORDS),
    .AW    (AW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (load_beat),
    .waddr_i (table_index_i),
    .wdata_i (data_word_i),
    .re_i    (word_beat),
    .raddr_i (rd_addr),
    .rdata_o (table_word)
  );

  // --------------------------------------------------------------------------
  // Hold the word and its self-rotation for the accumulator stage
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_start_q <= 1'b0;
      s1_last_q  <= 1'b0;
    end else begin
      s1_valid_q <= word_beat;
      s1_start_q <= !run_active_q;
      s1_last_q  <= last_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (word_beat) begin
      s1_word_q <= data_word_i;
      s1_rot_q  <= self_rotate(data_word_i);
    end
  end

  assign acc_ctrl.valid     = s1_valid_q;
  assign acc_ctrl.start     = s1_start_q;
  assign acc_ctrl.use_table = (variant_q == VAR_6105);

  bihc_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (acc_ctrl),
    .seed_i       (seed_of(variant_q)),
    .word_i       (s1_word_q),
    .rot_i        (s1_rot_q),
    .table_word_i (table_word),
    .state_o      (acc_state)
  );

  // --------------------------------------------------------------------------
  // Finalize once the last word has been folded in
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
    end else begin
      fin_valid_q <= s1_valid_q && s1_last_q;
    end
  end

  bihc_final u_final (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (fin_valid_q),
    .variant_i (variant_q),
    .state_i   (acc_state),
    .valid_o   (res_valid),
    .result_o  (res_data)
  );

  bihc_out_fifo #(
    .DEPTH (OUT_FIFO_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res_data),
    .pop_i   (out_ready_i),
    .valid_o (out_valid_o),
    .data_o  (out_data)
  );

  assign checksum_first_o  = out_data.first;
  assign checksum_second_o = out_data.second;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTH
  a_reserved_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reserved_q <= RW'(OUT_FIFO_DEPTH))
    else $error("pending result count exceeds queue depth");

  a_out_reserved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (reserved_q != '0))
    else $error("result offered without a reservation");

  a_last_closes_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reserve |=> (!run_active_q && (pos_q == '0)))
    else $error("last word did not close the run");

  a_fin_to_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_valid_q |=> res_valid)
    else $error("finalization did not produce a result");
`endif

endmodule

// ----- rtl/bihc_table_mem.sv -----
// ----------------------------------------------------------------------------
// bihc_table_mem: boot-code table storage
// Single-port-write, registered-read memory holding the boot-code table.
// ----------------------------------------------------------------------------
module bihc_table_mem
  import bihc_pkg::*;
#(
  parameter int WORDS = TABLE_WORDS_DEF,
  parameter int AW    = $clog2(WORDS)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [WORD_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] mem [WORDS];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/bihc_accum.sv -----
// ----------------------------------------------------------------------------
// bihc_accum: per-word accumulator update
// Seeds on run start, then folds one image word into the six accumulators.
// ----------------------------------------------------------------------------
module bihc_accum
  import bihc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  acc_ctrl_t         ctrl_i,
  input  logic [WORD_W-1:0] seed_i,
  input  logic [WORD_W-1:0] word_i,
  input  logic [WORD_W-1:0] rot_i,
  input  logic [WORD_W-1:0] table_word_i,
  output acc_state_t        state_o
);

  acc_state_t state_q, state_d, base;
  logic [WORD_W:0]   sum_ext;
  logic [WORD_W-1:0] rs_new;
  logic [WORD_W-1:0] tmix_term;

  always_comb begin
    if (ctrl_i.start) begin
      base = '{seed_i, seed_i, seed_i, seed_i, seed_i, seed_i};
    end else begin
      base = state_q;
    end

    sum_ext   = {1'b0, base.running_sum} + {1'b0, word_i};
    rs_new    = base.rotate_sum + rot_i;
    tmix_term = word_i ^ (ctrl_i.use_table ? table_word_i : rs_new);

    state_d.running_sum   = sum_ext[WORD_W-1:0];
    state_d.carry_count   = base.carry_count + {{(WORD_W-1){1'b0}}, sum_ext[WORD_W]};
    state_d.xor_acc       = base.xor_acc ^ word_i;
    state_d.rotate_sum    = rs_new;
    if (base.mix_value < word_i) begin
      state_d.mix_value = sum_ext[WORD_W-1:0] ^ word_i ^ base.mix_value;
    end else begin
      state_d.mix_value = base.mix_value ^ rot_i;
    end
    state_d.table_mix_sum = base.table_mix_sum + tmix_term;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (ctrl_i.valid) begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

// ----- rtl/bihc_final.sv -----
// ----------------------------------------------------------------------------
// bihc_final: checksum finalization
// Registers the xor or product term, then combines it with the third term.
// ----------------------------------------------------------------------------
module bihc_final
  import bihc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [VARIANT_W-1:0] variant_i,
  input  acc_state_t           state_i,
  output logic                 valid_o,
  output result_t              result_o
);

  logic              valid_q;
  logic [WORD_W-1:0] x1_q, c1_q, x2_q, c2_q;
  logic              use_mul;
  logic              use_add;

  assign use_mul = (variant_i == VAR_6106);
  assign use_add = (variant_i == VAR_6103) || (variant_i == VAR_6106);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      x1_q <= use_mul ? state_i.running_sum * state_i.carry_count
                      : state_i.running_sum ^ state_i.carry_count;
      x2_q <= use_mul ? state_i.rotate_sum * state_i.mix_value
                      : state_i.rotate_sum ^ state_i.mix_value;
      c1_q <= state_i.xor_acc;
      c2_q <= state_i.table_mix_sum;
    end
  end

  assign valid_o         = valid_q;
  assign result_o.first  = use_add ? x1_q + c1_q : x1_q ^ c1_q;
  assign result_o.second = use_add ? x2_q + c2_q : x2_q ^ c2_q;

endmodule

// ----- rtl/bihc_out_fifo.sv -----
// ----------------------------------------------------------------------------
// bihc_out_fifo: result queue
// Small register queue that decouples the result pipeline from the receiver.
// ----------------------------------------------------------------------------
module bihc_out_fifo
  import bihc_pkg::*;
#(
  parameter int DEPTH = OUT_FIFO_DEPTH,
  parameter int PW    = $clog2(DEPTH)
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  input  logic    pop_i,
  output logic    valid_o,
  output result_t data_o
);

  localparam int CW = $clog2(DEPTH + 1);

  result_t         buf_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   count_q;
  logic            do_pop;

  assign do_pop = pop_i && (count_q != '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + CW'(push_i) - CW'(do_pop);
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = buf_q[rd_ptr_q];

endmodule
